### sv/ccmt_pkg.sv
// ----------------------------------------------------------------------------
// ccmt_pkg
// shared constants and types of the microsecond timebase
// ----------------------------------------------------------------------------
`default_nettype none

package ccmt_pkg;

  // width of the free-running cycle counter, 16 to 32
  localparam int COUNTER_BITS = 32;

  localparam int ACT_W      = 2;
  localparam int VALUE_W    = 32;
  localparam int HZ_W       = 32;
  localparam int TOTAL_W    = 64;
  localparam int US_W       = 20;
  localparam int PP_W       = VALUE_W + US_W;
  localparam int DIV_STEPS  = TOTAL_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [US_W-1:0] US_PER_SECOND  = US_W'(1000000);
  localparam logic [HZ_W-1:0] CLOCK_HZ_RESET = HZ_W'(600000000);

  // item actions
  localparam logic [ACT_W-1:0] ACT_SEED    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_NOW     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CONVERT = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NONE    = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic add;
    logic div_step;
    logic out_load;
  } ccmt_cmd_t;

endpackage

`default_nettype wire

### sv/cycle_count_microsecond_timebase_core.sv
// ----------------------------------------------------------------------------
// cycle_count_microsecond_timebase_core
// microsecond timebase from samples of a free-running cycle counter
// ----------------------------------------------------------------------------
// Each item carries an action and a counter value and yields exactly one
// time_us result. seed records the sample, clears the 64-bit cycle total and
// returns 0; now adds the wrapping sample difference to the total and returns
// (total * 1e6 mod 2^64) / clock_hz; convert returns value * 1e6 / clock_hz
// truncated to 32 bits; the unused action returns 0 and changes nothing. A
// zero clock_hz gives all ones. For now and convert the item passes through a
// low-half and a high-half state on the shared 32x20 multiplier, a state
// that folds the two partial products, the radix-2 restoring divider and a
// final state that loads the output register; seed and the unused action
// go from accept straight to that final state. A finished item waits there
// while the previous result is held by out_stall. One item is in work at a
// time; a new item is taken while the previous result still waits in the
// output register. The user must write clock_hz only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module cycle_count_microsecond_timebase_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // item input
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [ccmt_pkg::ACT_W-1:0]      in_action,
  input  wire logic [ccmt_pkg::VALUE_W-1:0]    in_counter_value,
  // result output
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [ccmt_pkg::TOTAL_W-1:0]    out_time_us,
  // clock_hz register
  input  wire logic                            cfg_wr_en,
  input  wire logic [ccmt_pkg::HZ_W-1:0]       cfg_wr_data
);

  // commands from the sequencer to the datapath
  ccmt_pkg::ccmt_cmd_t cmd;

  // sequencer: handshakes, step counter, output valid
  ccmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath: state update at accept, product, quotient, result register
  ccmt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_action        (in_action),
    .in_counter_value (in_counter_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_time_us      (out_time_us)
  );

endmodule

`default_nettype wire

### sv/ccmt_dp.sv
// ----------------------------------------------------------------------------
// ccmt_dp
// datapath: cycle total, shared 32x20 multiplier and radix-2 divider
// ----------------------------------------------------------------------------
`default_nettype none

module ccmt_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire ccmt_pkg::ccmt_cmd_t                cmd,
  input  wire logic [ccmt_pkg::ACT_W-1:0]         in_action,
  input  wire logic [ccmt_pkg::VALUE_W-1:0]       in_counter_value,
  input  wire logic                               cfg_wr_en,
  input  wire logic [ccmt_pkg::HZ_W-1:0]          cfg_wr_data,
  output logic      [ccmt_pkg::TOTAL_W-1:0]       out_time_us
);

  logic [ccmt_pkg::HZ_W-1:0]          clock_hz_r;
  logic [ccmt_pkg::COUNTER_BITS-1:0]  last_r, last_nxt;
  logic [ccmt_pkg::TOTAL_W-1:0]       total_r, total_nxt;
  logic [ccmt_pkg::VALUE_W-1:0]       value_r;
  logic [ccmt_pkg::ACT_W-1:0]         act_r;
  logic [ccmt_pkg::PP_W-1:0]          pp_r, pp_nxt;
  logic [ccmt_pkg::TOTAL_W-1:0]       num_r, num_nxt;
  logic [ccmt_pkg::HZ_W-1:0]          rem_r, rem_nxt;
  logic [ccmt_pkg::TOTAL_W-1:0]       out_r, out_nxt;

  logic [ccmt_pkg::COUNTER_BITS-1:0]  sample;
  logic [ccmt_pkg::COUNTER_BITS-1:0]  delta;
  logic [ccmt_pkg::TOTAL_W-1:0]       operand;
  logic [ccmt_pkg::VALUE_W-1:0]       mul_a;
  logic [ccmt_pkg::PP_W-1:0]          mul_p;
  logic [ccmt_pkg::HZ_W:0]            rem_sh;
  logic                               ge;

  assign sample  = in_counter_value[ccmt_pkg::COUNTER_BITS-1:0];
  assign delta   = sample - last_r;
  assign operand = (act_r == ccmt_pkg::ACT_NOW) ? total_r
                                                : ccmt_pkg::TOTAL_W'(value_r);
  assign mul_a   = cmd.mul_hi ? operand[63:32] : operand[31:0];
  assign mul_p   = ccmt_pkg::PP_W'(mul_a) * ccmt_pkg::PP_W'(ccmt_pkg::US_PER_SECOND);

  // one restoring divide step
  assign rem_sh  = {rem_r, num_r[ccmt_pkg::TOTAL_W-1]};
  assign ge      = rem_sh >= {1'b0, clock_hz_r};

  always_comb begin
    last_nxt  = last_r;
    total_nxt = total_r;
    if (cmd.load) begin
      case (in_action)
        ccmt_pkg::ACT_SEED: begin
          last_nxt  = sample;
          total_nxt = '0;
        end
        ccmt_pkg::ACT_NOW: begin
          last_nxt  = sample;
          total_nxt = total_r + ccmt_pkg::TOTAL_W'(delta);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    pp_nxt  = pp_r;
    num_nxt = num_r;
    rem_nxt = rem_r;
    if (cmd.mul_lo) begin
      pp_nxt = mul_p;
    end else if (cmd.mul_hi) begin
      pp_nxt  = mul_p;
      num_nxt = ccmt_pkg::TOTAL_W'(pp_r);
    end else if (cmd.add) begin
      num_nxt = num_r + {pp_r[31:0], 32'b0};
      rem_nxt = '0;
    end else if (cmd.div_step) begin
      num_nxt = {num_r[ccmt_pkg::TOTAL_W-2:0], ge};
      rem_nxt = ge ? ccmt_pkg::HZ_W'(rem_sh - {1'b0, clock_hz_r})
                   : rem_sh[ccmt_pkg::HZ_W-1:0];
    end
  end

  always_comb begin
    out_nxt = out_r;
    if (cmd.out_load) begin
      case (act_r)
        ccmt_pkg::ACT_NOW:     out_nxt = num_r;
        ccmt_pkg::ACT_CONVERT: out_nxt = ccmt_pkg::TOTAL_W'(num_r[31:0]);
        default:               out_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= ccmt_pkg::CLOCK_HZ_RESET;
      last_r     <= '0;
      total_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        clock_hz_r <= cfg_wr_data;
      end
      last_r  <= last_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= in_counter_value;
      act_r   <= in_action;
    end
    pp_r  <= pp_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    out_r <= out_nxt;
  end

  assign out_time_us = out_r;

endmodule

`default_nettype wire

### sv/ccmt_ctrl.sv
// ----------------------------------------------------------------------------
// ccmt_ctrl
// sequencer: accept, multiply, divide, hand off to the output register
// ----------------------------------------------------------------------------
`default_nettype none

module ccmt_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic [ccmt_pkg::ACT_W-1:0]   in_action,
  output logic                              in_stall,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output ccmt_pkg::ccmt_cmd_t               cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL_LO = 3'd1;
  localparam logic [2:0] S_MUL_HI = 3'd2;
  localparam logic [2:0] S_ADD    = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  localparam logic [ccmt_pkg::DIV_CNT_W-1:0] CNT_LAST =
    ccmt_pkg::DIV_CNT_W'(ccmt_pkg::DIV_STEPS - 1);

  logic [2:0]                        state_r, state_nxt;
  logic [ccmt_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic                              accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if ((in_action == ccmt_pkg::ACT_NOW) || (in_action == ccmt_pkg::ACT_CONVERT)) begin
            state_nxt = S_MUL_LO;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + ccmt_pkg::DIV_CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("accepted item did not start");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && (cnt_r == CNT_LAST) |=> (state_r == S_FIN))
    else $error("divide did not finish after last step");

  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && (!out_valid_r || !out_stall) |=> out_valid_r)
    else $error("finished item not presented");

  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result raised outside finish");
`endif

endmodule

`default_nettype wire
